/* hw/rtl/bec_pkg.sv */
// ----------------------------------------------------------------------------
// bec_pkg
// Shared codes, register map and reset values of the button event classifier.
// ----------------------------------------------------------------------------
package bec_pkg;

    // default timer width
    localparam int BEC_TIMER_WIDTH = 16;

    // register bus geometry
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    // register indexes (byte address is 4 * index)
    localparam logic [2:0] REG_MODE        = 3'd0;
    localparam logic [2:0] REG_DEBOUNCE    = 3'd1;
    localparam logic [2:0] REG_AUTORESET   = 3'd2;
    localparam logic [2:0] REG_BAND_SHORT  = 3'd3;
    localparam logic [2:0] REG_BAND_LONG   = 3'd4;
    localparam logic [2:0] REG_BAND_LONGER = 3'd5;
    localparam logic [2:0] REG_MODULUS     = 3'd6;

    // register reset values
    localparam logic [3:0]  RST_MODE        = 4'd0;
    localparam logic [15:0] RST_DEBOUNCE    = 16'd10;
    localparam logic [15:0] RST_AUTORESET   = 16'd1000;
    localparam logic [15:0] RST_BAND_SHORT  = 16'd2;
    localparam logic [15:0] RST_BAND_LONG   = 16'd100;
    localparam logic [15:0] RST_BAND_LONGER = 16'd300;
    localparam logic [7:0]  RST_MODULUS     = 8'd4;

    // operating modes
    localparam logic [3:0] MODE_OFF        = 4'd0;
    localparam logic [3:0] MODE_TOGGLE     = 4'd1;
    localparam logic [3:0] MODE_RELEASE    = 4'd2;
    localparam logic [3:0] MODE_COUNT_MAN  = 4'd3;
    localparam logic [3:0] MODE_COUNT_AUTO = 4'd4;
    localparam logic [3:0] MODE_PUSH       = 4'd5;
    localparam logic [3:0] MODE_LATCH      = 4'd6;
    localparam logic [3:0] MODE_CONTINUOUS = 4'd7;
    localparam logic [3:0] MODE_TIMED2     = 4'd8;
    localparam logic [3:0] MODE_TIMED3     = 4'd9;

    // input actions
    localparam logic [1:0] ACT_SAMPLE  = 2'd0;
    localparam logic [1:0] ACT_CLEAR   = 2'd1;
    localparam logic [1:0] ACT_HOLDOFF = 2'd2;

    // event codes
    localparam logic [2:0] EV_NONE   = 3'd0;
    localparam logic [2:0] EV_ON     = 3'd1;
    localparam logic [2:0] EV_OFF    = 3'd2;
    localparam logic [2:0] EV_LONG   = 3'd3;
    localparam logic [2:0] EV_LONGER = 3'd4;
    localparam logic [2:0] EV_COUNT  = 3'd5;

    // switch states
    localparam logic [1:0] ST_OFF    = 2'd0;
    localparam logic [1:0] ST_ON     = 2'd1;
    localparam logic [1:0] ST_LONG   = 2'd2;
    localparam logic [1:0] ST_LONGER = 2'd3;

    // one result item
    typedef struct packed {
        logic [2:0] event_res;
        logic [1:0] switch_state;
        logic [7:0] count_value;
    } t_result;

endpackage

/* hw/rtl/button_event_classifier.sv */
// ----------------------------------------------------------------------------
// button_event_classifier
// Debounce, edge, counter and press-duration classifier for one pushbutton.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries an action and a sampled
//   active-low button level; every accepted item yields exactly one result
//   on the output channel (o_out_valid / i_out_stall) with event code,
//   switch state and counter value.
//   A result is registered: it is loaded into the output register (or the
//   skid register while the output is held) when its item is accepted. One
//   item per cycle is taken while o_in_stall is low, set by the single state
//   update between the input and the result register.
//   A skid register behind the output register lets one more item in while a
//   result is held by a stalled receiver; o_in_stall rises only when both are
//   full, so nothing is lost or repeated.
//   Configuration goes through the APB-style port, register i at byte 4*i; the
//   user writes only while the block is idle (not enforced); reads return it.
//   Reset (i_rst_n low, synchronous) restores register defaults, clears all
//   button state and empties the output stages.
// ----------------------------------------------------------------------------
module button_event_classifier #(
    parameter int TIMER_WIDTH = bec_pkg::BEC_TIMER_WIDTH
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // input channel
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic [1:0]                 i_action,
    input  logic                       i_pin_level,
    // output channel
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [2:0]                 o_event_res,
    output logic [1:0]                 o_switch_state,
    output logic [7:0]                 o_count_value,
    // configuration port
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [bec_pkg::ADDR_W-1:0] paddr,
    input  logic [bec_pkg::DATA_W-1:0] pwdata,
    output logic [bec_pkg::DATA_W-1:0] prdata,
    output logic                       pready
);

    localparam int CmpW = (TIMER_WIDTH > 16) ? TIMER_WIDTH : 16;
    localparam logic [TIMER_WIDTH-1:0] TimerMax = {TIMER_WIDTH{1'b1}};

    // configuration registers
    logic [3:0]  r_mode;
    logic [15:0] r_debounce_limit;
    logic [15:0] r_autoreset_limit;
    logic [15:0] r_band_short;
    logic [15:0] r_band_long;
    logic [15:0] r_band_longer;
    logic [7:0]  r_count_modulus;

    // button state
    logic                   r_last_level,      n_last_level;
    logic                   r_held_flag,       n_held_flag;
    logic                   r_release_pending, n_release_pending;
    logic [TIMER_WIDTH-1:0] r_hold_ticks,      n_hold_ticks;
    logic [TIMER_WIDTH-1:0] r_debounce_ticks,  n_debounce_ticks;
    logic [TIMER_WIDTH-1:0] r_idle_ticks,      n_idle_ticks;
    logic [7:0]             r_press_count,     n_press_count;
    logic [1:0]             r_state_code,      n_state_code;

    // output and skid stages
    logic             r_out_valid;
    bec_pkg::t_result r_out;
    logic             r_skd_valid;
    bec_pkg::t_result r_skd;

    logic             in_acc;
    logic             out_free;
    logic             cfg_wr;
    logic [2:0]       cfg_idx;
    logic             pressed;
    logic             counting;
    logic [2:0]       ev;
    logic [8:0]       cnt_inc;
    bec_pkg::t_result res;

    // handshake
    assign in_acc     = i_in_valid && !r_skd_valid;
    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_skd_valid;

    assign o_out_valid    = r_out_valid;
    assign o_event_res    = r_out.event_res;
    assign o_switch_state = r_out.switch_state;
    assign o_count_value  = r_out.count_value;

    // register bus decode
    assign pready  = 1'b1;
    assign cfg_idx = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_comb begin
        prdata = '0;
        case (cfg_idx)
            bec_pkg::REG_MODE:        prdata = {28'd0, r_mode};
            bec_pkg::REG_DEBOUNCE:    prdata = {16'd0, r_debounce_limit};
            bec_pkg::REG_AUTORESET:   prdata = {16'd0, r_autoreset_limit};
            bec_pkg::REG_BAND_SHORT:  prdata = {16'd0, r_band_short};
            bec_pkg::REG_BAND_LONG:   prdata = {16'd0, r_band_long};
            bec_pkg::REG_BAND_LONGER: prdata = {16'd0, r_band_longer};
            bec_pkg::REG_MODULUS:     prdata = {24'd0, r_count_modulus};
            default:                  prdata = '0;
        endcase
    end

    // configuration write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode            <= bec_pkg::RST_MODE;
            r_debounce_limit  <= bec_pkg::RST_DEBOUNCE;
            r_autoreset_limit <= bec_pkg::RST_AUTORESET;
            r_band_short      <= bec_pkg::RST_BAND_SHORT;
            r_band_long       <= bec_pkg::RST_BAND_LONG;
            r_band_longer     <= bec_pkg::RST_BAND_LONGER;
            r_count_modulus   <= bec_pkg::RST_MODULUS;
        end else if (cfg_wr) begin
            case (cfg_idx)
                bec_pkg::REG_MODE:        r_mode            <= pwdata[3:0];
                bec_pkg::REG_DEBOUNCE:    r_debounce_limit  <= pwdata[15:0];
                bec_pkg::REG_AUTORESET:   r_autoreset_limit <= pwdata[15:0];
                bec_pkg::REG_BAND_SHORT:  r_band_short      <= pwdata[15:0];
                bec_pkg::REG_BAND_LONG:   r_band_long       <= pwdata[15:0];
                bec_pkg::REG_BAND_LONGER: r_band_longer     <= pwdata[15:0];
                bec_pkg::REG_MODULUS:     r_count_modulus   <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // next button state and event for the incoming item
    always_comb begin
        n_last_level      = r_last_level;
        n_held_flag       = r_held_flag;
        n_release_pending = r_release_pending;
        n_hold_ticks      = r_hold_ticks;
        n_debounce_ticks  = r_debounce_ticks;
        n_idle_ticks      = r_idle_ticks;
        n_press_count     = r_press_count;
        n_state_code      = r_state_code;
        ev                = bec_pkg::EV_NONE;
        pressed           = !i_pin_level;
        counting          = (r_mode == bec_pkg::MODE_COUNT_MAN) ||
                            (r_mode == bec_pkg::MODE_COUNT_AUTO);
        cnt_inc           = '0;

        case (i_action)
            bec_pkg::ACT_SAMPLE: begin
                case (r_mode)
                    bec_pkg::MODE_TOGGLE: begin
                        if (i_pin_level != r_last_level) begin
                            if (pressed) begin
                                n_state_code = bec_pkg::ST_ON;
                                ev           = bec_pkg::EV_ON;
                            end else begin
                                n_state_code = bec_pkg::ST_OFF;
                                ev           = bec_pkg::EV_OFF;
                            end
                            n_last_level = i_pin_level;
                        end
                    end
                    bec_pkg::MODE_RELEASE, bec_pkg::MODE_COUNT_MAN,
                    bec_pkg::MODE_COUNT_AUTO: begin
                        if (pressed) begin
                            n_held_flag       = 1'b1;
                            n_release_pending = 1'b1;
                            n_state_code      = bec_pkg::ST_ON;
                        end else begin
                            n_held_flag  = 1'b0;
                            n_state_code = bec_pkg::ST_OFF;
                            // idle timeout clears a nonzero counter
                            if (r_mode == bec_pkg::MODE_COUNT_AUTO &&
                                r_press_count != 8'd0) begin
                                n_idle_ticks = (r_idle_ticks == TimerMax) ?
                                               r_idle_ticks : r_idle_ticks + 1'b1;
                                if (CmpW'(r_idle_ticks) > CmpW'(r_autoreset_limit)) begin
                                    n_press_count = 8'd0;
                                    n_idle_ticks  = '0;
                                    ev            = bec_pkg::EV_COUNT;
                                end
                            end
                        end
                        // release completes a press
                        if (!n_held_flag && n_release_pending) begin
                            if (r_mode == bec_pkg::MODE_RELEASE) begin
                                ev = bec_pkg::EV_ON;
                            end else begin
                                n_idle_ticks = '0;
                                cnt_inc      = {1'b0, n_press_count} + 9'd1;
                                if (r_count_modulus != 8'd0 &&
                                    cnt_inc >= {1'b0, r_count_modulus}) begin
                                    n_press_count = 8'd0;
                                end else begin
                                    n_press_count = cnt_inc[7:0];
                                end
                                ev = bec_pkg::EV_COUNT;
                            end
                            n_release_pending = 1'b0;
                        end
                    end
                    bec_pkg::MODE_PUSH, bec_pkg::MODE_LATCH: begin
                        if (pressed) begin
                            n_debounce_ticks = '0;
                            if (!r_held_flag) begin
                                if (r_mode == bec_pkg::MODE_LATCH &&
                                    r_state_code == bec_pkg::ST_ON) begin
                                    n_state_code = bec_pkg::ST_OFF;
                                    ev           = bec_pkg::EV_OFF;
                                end else begin
                                    n_state_code = bec_pkg::ST_ON;
                                    ev           = bec_pkg::EV_ON;
                                end
                                n_held_flag = 1'b1;
                            end
                        end else begin
                            if (r_mode == bec_pkg::MODE_PUSH) begin
                                n_state_code = bec_pkg::ST_OFF;
                            end
                            // rearm once released long enough
                            n_debounce_ticks = (r_debounce_ticks == TimerMax) ?
                                               r_debounce_ticks : r_debounce_ticks + 1'b1;
                            if (CmpW'(r_debounce_ticks) > CmpW'(r_debounce_limit)) begin
                                n_held_flag      = 1'b0;
                                n_debounce_ticks = '0;
                            end
                        end
                    end
                    bec_pkg::MODE_CONTINUOUS: begin
                        if (pressed) begin
                            n_state_code = bec_pkg::ST_ON;
                            ev           = bec_pkg::EV_ON;
                        end else begin
                            n_state_code = bec_pkg::ST_OFF;
                        end
                    end
                    bec_pkg::MODE_TIMED2, bec_pkg::MODE_TIMED3: begin
                        if (pressed) begin
                            n_held_flag       = 1'b1;
                            n_release_pending = 1'b1;
                            n_hold_ticks      = (r_hold_ticks == TimerMax) ?
                                                r_hold_ticks : r_hold_ticks + 1'b1;
                        end else begin
                            n_held_flag = 1'b0;
                        end
                        // classify the press length on release
                        if (!n_held_flag && n_release_pending) begin
                            if (r_mode == bec_pkg::MODE_TIMED3 &&
                                CmpW'(n_hold_ticks) >= CmpW'(r_band_longer)) begin
                                n_state_code = bec_pkg::ST_LONGER;
                                ev           = bec_pkg::EV_LONGER;
                            end else if (CmpW'(n_hold_ticks) >= CmpW'(r_band_long)) begin
                                n_state_code = bec_pkg::ST_LONG;
                                ev           = bec_pkg::EV_LONG;
                            end else if (CmpW'(n_hold_ticks) >= CmpW'(r_band_short)) begin
                                if (r_state_code != bec_pkg::ST_OFF) begin
                                    n_state_code = bec_pkg::ST_OFF;
                                    ev           = bec_pkg::EV_OFF;
                                end else begin
                                    n_state_code = bec_pkg::ST_ON;
                                    ev           = bec_pkg::EV_ON;
                                end
                            end
                            n_hold_ticks      = '0;
                            n_release_pending = 1'b0;
                        end
                    end
                    default: ;
                endcase
            end
            bec_pkg::ACT_CLEAR: begin
                if (counting && r_press_count != 8'd0) begin
                    n_idle_ticks  = '0;
                    n_press_count = 8'd0;
                    ev            = bec_pkg::EV_COUNT;
                end
            end
            bec_pkg::ACT_HOLDOFF: begin
                n_idle_ticks = '0;
            end
            default: ;
        endcase

        res.event_res    = ev;
        res.switch_state = n_state_code;
        res.count_value  = counting ? n_press_count : 8'd0;
    end

    // button state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_level      <= 1'b1;
            r_held_flag       <= 1'b0;
            r_release_pending <= 1'b0;
            r_hold_ticks      <= '0;
            r_debounce_ticks  <= '0;
            r_idle_ticks      <= '0;
            r_press_count     <= 8'd0;
            r_state_code      <= bec_pkg::ST_OFF;
        end else if (in_acc) begin
            r_last_level      <= n_last_level;
            r_held_flag       <= n_held_flag;
            r_release_pending <= n_release_pending;
            r_hold_ticks      <= n_hold_ticks;
            r_debounce_ticks  <= n_debounce_ticks;
            r_idle_ticks      <= n_idle_ticks;
            r_press_count     <= n_press_count;
            r_state_code      <= n_state_code;
        end
    end

    // output register with skid stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_skd_valid <= 1'b0;
        end else begin
            if (out_free) begin
                if (r_skd_valid) begin
                    r_out_valid <= 1'b1;
                    r_out       <= r_skd;
                    r_skd_valid <= 1'b0;
                end else begin
                    r_out_valid <= in_acc;
                    if (in_acc) begin
                        r_out <= res;
                    end
                end
            end else if (in_acc) begin
                r_skd_valid <= 1'b1;
                r_skd       <= res;
            end
        end
    end

endmodule
